>>> design/rbs_pkg.sv
package rbs_pkg;

  localparam int CH_BITS      = 8;
  localparam int PIX_BITS     = 3 * CH_BITS;
  localparam int ROW_BITS     = 13;
  localparam int OROW_BITS    = 12;
  localparam int FW_BITS      = 11;
  localparam int FH_BITS      = 13;
  localparam int CFG_BITS     = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int SUM_BITS     = 12;
  localparam int RECIP_BITS   = 15;
  localparam int RECIP_SHIFT  = 16;
  localparam int PROD_BITS    = SUM_BITS + RECIP_BITS;
  localparam logic [SUM_BITS-1:0] SUM_MAX = 12'd2295;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  // multiply-shift reciprocals, exact for sums up to 9*255
  localparam logic [RECIP_BITS-1:0] RECIP_NINE = 15'd7282;
  localparam logic [RECIP_BITS-1:0] RECIP_SIX  = 15'd10923;
  localparam logic [RECIP_BITS-1:0] RECIP_FOUR = 15'd16384;

  typedef enum logic [1:0] {
    DIV_NINE,
    DIV_SIX,
    DIV_FOUR
  } div_e;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic               cmd;
    logic [CH_BITS-1:0] red_in;
    logic [CH_BITS-1:0] green_in;
    logic [CH_BITS-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red_out;
    logic [CH_BITS-1:0] green_out;
    logic [CH_BITS-1:0] blue_out;
    logic               frame_done;
  } out_t;

  typedef struct packed {
    logic emit;
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic done;
  } meta_t;

  localparam int META_BITS = $bits(meta_t);

  function automatic logic [RECIP_BITS-1:0] recip(input div_e d);
    logic [RECIP_BITS-1:0] m;
    unique case (d)
      DIV_NINE: m = RECIP_NINE;
      DIV_SIX:  m = RECIP_SIX;
      DIV_FOUR: m = RECIP_FOUR;
      default:  m = RECIP_NINE;
    endcase
    return m;
  endfunction

endpackage

>>> design/rbs_front.sv
module rbs_front import rbs_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [CFG_BITS-1:0]          cfg_data_i,
  input  logic                         push_i,
  input  in_t                          in_data_i,
  output logic [$clog2(MAX_WIDTH)-1:0] x_o,
  output pix_t                         bot_o,
  output meta_t                        meta_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [FW_BITS-1:0]   fw_q;
  logic [FH_BITS-1:0]   fh_q;
  logic [WW-1:0]        eff_w;
  logic [FH_BITS-1:0]   eff_h;
  logic [XW-1:0]        in_col_q, out_col_q;
  logic [ROW_BITS-1:0]  in_row_q;
  logic [OROW_BITS-1:0] out_row_q;
  logic [WW:0]          in_col_nx, out_col_nx;
  logic [FH_BITS-1:0]   out_row_nx;
  logic                 in_col_last;
  meta_t                meta;

  always_comb begin
    if (fw_q < 11'd2) begin
      eff_w = WW'(2);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_q);
    end
    if (fh_q < 13'd2) begin
      eff_h = FH_BITS'(2);
    end else if (32'(fh_q) > 32'(HEIGHT_LIMIT)) begin
      eff_h = FH_BITS'(HEIGHT_LIMIT);
    end else begin
      eff_h = fh_q;
    end
  end

  assign in_col_nx   = (WW+1)'(in_col_q) + (WW+1)'(1);
  assign out_col_nx  = (WW+1)'(out_col_q) + (WW+1)'(1);
  assign out_row_nx  = FH_BITS'(out_row_q) + FH_BITS'(1);
  assign in_col_last = in_col_nx >= (WW+1)'(eff_w);

  always_comb begin
    meta.emit   = (in_row_q >= 13'd2) || (in_row_q == 13'd1 && in_col_q != '0);
    meta.left   = out_col_q == '0;
    meta.right  = out_col_nx >= (WW+1)'(eff_w);
    meta.top    = out_row_q == '0;
    meta.bottom = out_row_nx >= eff_h;
    meta.done   = meta.right && meta.bottom;
  end

  assign meta_o = meta;
  assign x_o    = in_col_q;
  assign bot_o  = (in_row_q < eff_h && !in_data_i.cmd) ?
                  {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= 11'd640;
      fh_q      <= 13'd480;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  fw_q <= cfg_data_i[FW_BITS-1:0];
        CFG_HEIGHT: fh_q <= cfg_data_i[FH_BITS-1:0];
        default:    fw_q <= fw_q;
      endcase
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (push_i) begin
      if (meta.emit && meta.done) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if (in_col_last) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 13'd1;
        end else begin
          in_col_q <= in_col_nx[XW-1:0];
        end
        if (meta.emit) begin
          if (meta.right) begin
            out_col_q <= '0;
            out_row_q <= out_row_nx[OROW_BITS-1:0];
          end else begin
            out_col_q <= out_col_nx[XW-1:0];
          end
        end
      end
    end
  end

endmodule

>>> design/rbs_queue.sv
module rbs_queue import rbs_pkg::*; #(
  parameter int DW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] head_o
);

  localparam int DEPTH = 4;
  localparam int AW    = 2;

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 2'd1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 3'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

endmodule

>>> design/rbs_back.sv
module rbs_back import rbs_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] head_x_i,
  input  pix_t                         head_bot_i,
  input  meta_t                        head_meta_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output out_t                         out_data_o
);

  localparam int XW = $clog2(MAX_WIDTH);

  pix_t  older_mem [MAX_WIDTH];
  pix_t  prior_mem [MAX_WIDTH];

  logic             adv;
  logic             s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic [XW-1:0]    s1_x_q;
  pix_t             s1_bot_q, rd_top_q, rd_mid_q;
  meta_t            s1_meta_q, s2_meta_q;
  pix_t             win_q [9];
  logic [SUM_BITS-1:0] sum_r, sum_g, sum_b;
  logic [SUM_BITS-1:0] s3_r_q, s3_g_q, s3_b_q;
  div_e             div_sel, s3_div_q;
  logic             s3_done_q;
  logic [PROD_BITS-1:0] prod_r, prod_g, prod_b;
  out_t             out_q;

  assign adv   = !out_v_q || !out_stall_i;
  assign pop_o = adv && head_valid_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_top_q <= older_mem[head_x_i];
      rd_mid_q <= prior_mem[head_x_i];
    end
    if (adv && s1_v_q) begin
      older_mem[s1_x_q] <= rd_mid_q;
      prior_mem[s1_x_q] <= s1_bot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_x_q    <= head_x_i;
      s1_bot_q  <= head_bot_i;
      s1_meta_q <= head_meta_i;
    end
    if (adv) begin
      s2_meta_q <= s1_meta_q;
      s3_r_q    <= sum_r;
      s3_g_q    <= sum_g;
      s3_b_q    <= sum_b;
      s3_div_q  <= div_sel;
      s3_done_q <= s2_meta_q.done;
      out_q.red_out    <= prod_r[RECIP_SHIFT +: CH_BITS];
      out_q.green_out  <= prod_g[RECIP_SHIFT +: CH_BITS];
      out_q.blue_out   <= prod_b[RECIP_SHIFT +: CH_BITS];
      out_q.frame_done <= s3_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (adv) begin
      s1_v_q  <= head_valid_i;
      s2_v_q  <= s1_v_q && s1_meta_q.emit;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
      if (s1_v_q) begin
        for (int i = 0; i < 6; i++) win_q[i] <= win_q[i+3];
        win_q[6] <= rd_top_q;
        win_q[7] <= rd_mid_q;
        win_q[8] <= s1_bot_q;
      end
    end
  end

  // window index is column * 3 + row, column 0 oldest
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (!(c == 0 && s2_meta_q.left) && !(c == 2 && s2_meta_q.right) &&
            !(r == 0 && s2_meta_q.top) && !(r == 2 && s2_meta_q.bottom)) begin
          sum_r = sum_r + SUM_BITS'(win_q[c*3+r].red);
          sum_g = sum_g + SUM_BITS'(win_q[c*3+r].green);
          sum_b = sum_b + SUM_BITS'(win_q[c*3+r].blue);
        end
      end
    end
    if ((s2_meta_q.left || s2_meta_q.right) && (s2_meta_q.top || s2_meta_q.bottom)) begin
      div_sel = DIV_FOUR;
    end else if (s2_meta_q.left || s2_meta_q.right || s2_meta_q.top ||
                 s2_meta_q.bottom) begin
      div_sel = DIV_SIX;
    end else begin
      div_sel = DIV_NINE;
    end
  end

  assign prod_r = PROD_BITS'(s3_r_q) * PROD_BITS'(recip(s3_div_q));
  assign prod_g = PROD_BITS'(s3_g_q) * PROD_BITS'(recip(s3_div_q));
  assign prod_b = PROD_BITS'(s3_b_q) * PROD_BITS'(recip(s3_div_q));

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> (s3_r_q <= SUM_MAX && s3_g_q <= SUM_MAX && s3_b_q <= SUM_MAX))
    else $error("window sum out of range");

  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> s1_v_q)
    else $error("popped item lost in first stage");

endmodule

>>> design/rgb_box_smooth_three_by_three.sv
// channel  direction  handshake             payload
// in       input      in_valid_i/in_stall_o  in_data_i  (in_t)
// out      output     out_valid_o/out_stall_i out_data_o (out_t)
// cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; each taken item passes
// the registered queue, line-store read, window, sum and divide into output reg.
// Reset clears counters, window and queue; line stores are not cleared.
// A stalled output backs up the back pipeline; the 4-entry queue then fills
// and in_stall_o rises.
module rgb_box_smooth_three_by_three import rbs_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int DW = XW + PIX_BITS + META_BITS;

  logic          push, full, pop, head_valid;
  logic [XW-1:0] fx, hx;
  pix_t          fbot, hbot;
  meta_t         fmeta, hmeta;
  logic [DW-1:0] head;

  assign push       = in_valid_i && !full;
  assign in_stall_o = full;

  rbs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i(push), .in_data_i,
    .x_o(fx), .bot_o(fbot), .meta_o(fmeta)
  );

  rbs_queue #(.DW(DW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i({fx, fbot, fmeta}), .full_o(full),
    .pop_i(pop), .valid_o(head_valid), .head_o(head)
  );

  assign {hx, hbot, hmeta} = head;

  rbs_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .head_valid_i(head_valid), .head_x_i(hx), .head_bot_i(hbot),
    .head_meta_i(hmeta), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
